FILE: hw/rtl/tcw_pkg.sv
// Shared types and constants for the text console writer.
// Holds field widths, operation codes, register indexes, character codes
// and the sequencer state type. No dependencies.
`default_nettype none

package tcw_pkg;

  // Field widths.
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CHAR_W = 8;
  localparam int CELL_W = 16;
  localparam int FUNC_W = 2;
  localparam int PROD_W = COL_W + ROW_W;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS         = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRINT_ENABLE = 2'd2;

  localparam logic [COL_W-1:0] RESET_COLUMNS = 7'd80;
  localparam logic [ROW_W-1:0] RESET_ROWS    = 5'd25;

  // Default geometry.
  localparam int DEF_MAX_COLUMNS = 80;
  localparam int DEF_MAX_ROWS    = 25;
  localparam int DEF_TAB_STEP    = 4;

  // Operation codes.
  localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

  // Character codes with special handling on put.
  localparam logic [CHAR_W-1:0] CH_NUL = 8'd0;
  localparam logic [CHAR_W-1:0] CH_BS  = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB = 8'd9;
  localparam logic [CHAR_W-1:0] CH_LF  = 8'd10;
  localparam logic [CHAR_W-1:0] CH_VT  = 8'd11;
  localparam logic [CHAR_W-1:0] CH_FF  = 8'd12;
  localparam logic [CHAR_W-1:0] CH_CR  = 8'd13;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_MUL,
    S_EXEC,
    S_RDWAIT,
    S_SCMUL,
    S_MOVE,
    S_FILL,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/tcw_screen.sv
// Screen cell store: one write port and one registered read port.
// Depends on tcw_pkg for the cell width and the default depth.
`default_nettype none

module tcw_screen import tcw_pkg::*; #(
  parameter int DEPTH  = DEF_MAX_COLUMNS * DEF_MAX_ROWS,
  parameter int ADDR_W = 11
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [CELL_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [CELL_W-1:0] rdata
);

  logic [CELL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/text_console_writer.sv
// Text console writer top level: sequencer, cursor, configuration and result.
// Depends on tcw_pkg and tcw_screen.
//
// Usage: operations arrive as words on the input channel (in_valid/in_ready)
// and each produces exactly one result word on the output channel
// (out_valid/out_ready). func selects put, clear or read. The configuration
// port (cfg_write, cfg_index, cfg_data) sets columns, rows and print_enable
// and should only be written while no operation is in flight.
// A put without scrolling, a read, an ignored code or a disabled put passes
// through S_MUL, S_EXEC and S_DONE; a read inside the area also waits in
// S_RDWAIT. A clear zeroes all columns*rows cells in S_FILL. In a scroll the
// screen store, with one read and one write port, moves one cell per cycle
// (S_MOVE) and then zeroes the bottom row one cell per cycle (S_FILL).
// One shared multiplier forms every row base.
// After reset the block sweeps the whole store to zero and holds in_ready low
// until it is done; configuration writes are taken during that time.
// The result sits in an output register; if the receiver stalls, the next
// operation is still accepted and runs up to the point of handing over its
// result, where it waits for the register to free up.
`default_nettype none

module text_console_writer import tcw_pkg::*; #(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = DEF_MAX_ROWS,
  parameter int TAB_STEP    = DEF_TAB_STEP
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // Configuration
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  // Operation input
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [FUNC_W-1:0]     func,
  input  wire logic [CHAR_W-1:0]     character,
  input  wire logic [CHAR_W-1:0]     color,
  input  wire logic [COL_W-1:0]      read_column,
  input  wire logic [ROW_W-1:0]      read_row,
  // Result output
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic      [COL_W-1:0]      cursor_column,
  output logic      [ROW_W-1:0]      cursor_row,
  output logic      [CHAR_W-1:0]     cell_char,
  output logic      [CHAR_W-1:0]     cell_color,
  output logic                       scrolled
);

  localparam int CELL_COUNT = MAX_COLUMNS * MAX_ROWS;
  localparam int ADDR_W     = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int CNT_W      = $clog2(CELL_COUNT + 1);

  // Configuration registers and their clamped values.
  logic [COL_W-1:0] columns;
  logic [ROW_W-1:0] rows;
  logic             print_enable;
  logic [COL_W-1:0] cols_eff;
  logic [ROW_W-1:0] rows_eff;

  state_t state, state_next;

  logic [CNT_W-1:0]  fill_ptr, fill_ptr_next;
  logic [CNT_W-1:0]  fill_end, fill_end_next;
  logic [CNT_W-1:0]  prod, prod_next;

  logic [FUNC_W-1:0] op_func, op_func_next;
  logic [CHAR_W-1:0] op_char, op_char_next;
  logic [CHAR_W-1:0] op_color, op_color_next;
  logic [COL_W-1:0]  op_rc, op_rc_next;
  logic [ROW_W-1:0]  op_rr, op_rr_next;

  logic [COL_W-1:0]  cursor_x, cursor_x_next;
  logic [ROW_W-1:0]  cursor_y, cursor_y_next;

  logic [CHAR_W-1:0] res_char, res_char_next;
  logic [CHAR_W-1:0] res_color, res_color_next;
  logic              res_scrolled, res_scrolled_next;
  logic              out_load;

  // Shared multiplier.
  logic [ROW_W-1:0]  mul_b;
  logic [PROD_W-1:0] mul_full;

  // Put cursor arithmetic.
  logic              op_ignored;
  logic [COL_W+1:0]  x_adv;
  logic [ROW_W:0]    y_adv;
  logic              put_write;
  logic              put_scroll;

  // Screen store ports.
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [CELL_W-1:0] mem_rdata;

  tcw_screen #(
    .DEPTH  (CELL_COUNT),
    .ADDR_W (ADDR_W)
  ) u_screen (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    if (columns == '0) begin
      cols_eff = COL_W'(1);
    end else if (int'(columns) > MAX_COLUMNS) begin
      cols_eff = COL_W'(MAX_COLUMNS);
    end else begin
      cols_eff = columns;
    end
    if (rows == '0) begin
      rows_eff = ROW_W'(1);
    end else if (int'(rows) > MAX_ROWS) begin
      rows_eff = ROW_W'(MAX_ROWS);
    end else begin
      rows_eff = rows;
    end
  end

  assign mul_full = PROD_W'(cols_eff) * PROD_W'(mul_b);

  assign op_ignored = (op_char == CH_NUL) || (op_char == CH_BS) || (op_char == CH_VT) ||
                      (op_char == CH_FF) || (op_char == CH_CR);

  // Cursor advance for a put: control codes, wrap at the right edge, then
  // scroll when the cursor runs off the bottom.
  always_comb begin
    x_adv     = {2'b00, cursor_x};
    y_adv     = {1'b0, cursor_y};
    put_write = 1'b0;
    if (op_char == CH_LF) begin
      x_adv = '0;
      y_adv = {1'b0, cursor_y} + 1'b1;
    end else if (op_char == CH_TAB) begin
      x_adv = {2'b00, cursor_x} + (COL_W+2)'(TAB_STEP);
    end else begin
      put_write = (cursor_x < cols_eff) && (cursor_y < rows_eff);
      x_adv     = {2'b00, cursor_x} + 1'b1;
    end
    if (x_adv >= {2'b00, cols_eff}) begin
      x_adv = '0;
      y_adv = y_adv + 1'b1;
    end
    put_scroll = (y_adv >= {1'b0, rows_eff});
    if (put_scroll) begin
      x_adv = '0;
      y_adv = {1'b0, rows_eff - 1'b1};
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next        = state;
    fill_ptr_next     = fill_ptr;
    fill_end_next     = fill_end;
    prod_next         = prod;
    op_func_next      = op_func;
    op_char_next      = op_char;
    op_color_next     = op_color;
    op_rc_next        = op_rc;
    op_rr_next        = op_rr;
    cursor_x_next     = cursor_x;
    cursor_y_next     = cursor_y;
    res_char_next     = res_char;
    res_color_next    = res_color;
    res_scrolled_next = res_scrolled;
    out_load          = 1'b0;
    mul_b             = cursor_y;
    mem_we            = 1'b0;
    mem_waddr         = '0;
    mem_wdata         = '0;
    mem_re            = 1'b0;
    mem_raddr         = '0;

    unique case (state)
      S_INIT: begin
        mem_we        = 1'b1;
        mem_waddr     = fill_ptr[ADDR_W-1:0];
        fill_ptr_next = fill_ptr + 1'b1;
        if (fill_ptr == CNT_W'(CELL_COUNT - 1)) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          op_func_next      = func;
          op_char_next      = character;
          op_color_next     = color;
          op_rc_next        = read_column;
          op_rr_next        = read_row;
          res_char_next     = '0;
          res_color_next    = '0;
          res_scrolled_next = 1'b0;
          state_next        = S_MUL;
        end
      end

      S_MUL: begin
        priority if (op_func == FUNC_READ) begin
          mul_b = op_rr;
        end else if (op_func == FUNC_CLEAR) begin
          mul_b = rows_eff;
        end else begin
          mul_b = cursor_y;
        end
        prod_next  = CNT_W'(mul_full);
        state_next = S_EXEC;
      end

      S_EXEC: begin
        priority if (op_func == FUNC_PUT && print_enable && !op_ignored) begin
          if (put_write) begin
            mem_we    = 1'b1;
            mem_waddr = ADDR_W'(prod + CNT_W'(cursor_x));
            mem_wdata = {op_color, op_char};
          end
          cursor_x_next = x_adv[COL_W-1:0];
          cursor_y_next = y_adv[ROW_W-1:0];
          if (put_scroll) begin
            res_scrolled_next = 1'b1;
            state_next        = S_SCMUL;
          end else begin
            state_next = S_DONE;
          end
        end else if (op_func == FUNC_CLEAR) begin
          fill_ptr_next = '0;
          fill_end_next = prod;
          state_next    = S_FILL;
        end else if (op_func == FUNC_READ && op_rc < cols_eff && op_rr < rows_eff) begin
          mem_re     = 1'b1;
          mem_raddr  = ADDR_W'(prod + CNT_W'(op_rc));
          state_next = S_RDWAIT;
        end else begin
          state_next = S_DONE;
        end
      end

      S_RDWAIT: begin
        res_char_next  = mem_rdata[CHAR_W-1:0];
        res_color_next = mem_rdata[CELL_W-1:CHAR_W];
        state_next     = S_DONE;
      end

      S_SCMUL: begin
        // Number of cells that move up: all rows but the first.
        mul_b         = rows_eff - 1'b1;
        fill_ptr_next = '0;
        fill_end_next = CNT_W'(mul_full);
        state_next    = S_MOVE;
      end

      S_MOVE: begin
        // Read one row ahead while writing back the word read last cycle.
        if (fill_ptr != fill_end) begin
          mem_re    = 1'b1;
          mem_raddr = ADDR_W'(fill_ptr + CNT_W'(cols_eff));
        end
        if (fill_ptr != '0) begin
          mem_we    = 1'b1;
          mem_waddr = ADDR_W'(fill_ptr - 1'b1);
          mem_wdata = mem_rdata;
        end
        if (fill_ptr == fill_end) begin
          fill_end_next = fill_end + CNT_W'(cols_eff);
          state_next    = S_FILL;
        end else begin
          fill_ptr_next = fill_ptr + 1'b1;
        end
      end

      S_FILL: begin
        mem_we        = 1'b1;
        mem_waddr     = fill_ptr[ADDR_W-1:0];
        fill_ptr_next = fill_ptr + 1'b1;
        if ((fill_ptr + 1'b1) == fill_end) begin
          state_next = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_INIT;
      fill_ptr     <= '0;
      fill_end     <= '0;
      cursor_x     <= '0;
      cursor_y     <= '0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      fill_ptr     <= fill_ptr_next;
      fill_end     <= fill_end_next;
      cursor_x     <= cursor_x_next;
      cursor_y     <= cursor_y_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod         <= prod_next;
    op_func      <= op_func_next;
    op_char      <= op_char_next;
    op_color     <= op_color_next;
    op_rc        <= op_rc_next;
    op_rr        <= op_rr_next;
    res_char     <= res_char_next;
    res_color    <= res_color_next;
    res_scrolled <= res_scrolled_next;
    if (out_load) begin
      cursor_column <= cursor_x;
      cursor_row    <= cursor_y;
      cell_char     <= res_char;
      cell_color    <= res_color;
      scrolled      <= res_scrolled;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      columns      <= RESET_COLUMNS;
      rows         <= RESET_ROWS;
      print_enable <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_COLUMNS:      columns      <= cfg_data;
        REG_ROWS:         rows         <= cfg_data[ROW_W-1:0];
        REG_PRINT_ENABLE: print_enable <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // The store is never written past its last cell.
  a_waddr_range: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (int'(mem_waddr) < CELL_COUNT))
    else $error("screen write address out of range");

  // While moving rows up, the read always runs ahead of the write.
  a_move_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (state == S_MOVE && mem_re && mem_we) |-> (mem_raddr != mem_waddr))
    else $error("scroll read and write hit the same cell");

  // The cursor never leaves the largest possible screen.
  a_cursor_bound: assert property (@(posedge clk) disable iff (rst)
    (int'(cursor_x) < MAX_COLUMNS) && (int'(cursor_y) < MAX_ROWS))
    else $error("cursor outside the maximum screen");

  // A scrolling put always leaves the cursor at the start of a row.
  a_scroll_cursor: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && res_scrolled) |-> (cursor_x == '0))
    else $error("scroll left the cursor off column zero");

  // One operation at a time: the cycle after acceptance the block is busy.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("accepted a second word while busy");

endmodule

`default_nettype wire
